// File: hw/rtl/lfo_pkg.sv
`timescale 1ns / 1ps

package lfo_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned MsW     = 16;
  localparam int unsigned RateW   = 18;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned CntW    = 27;
  localparam int unsigned CfgIdxW = 2;

  // shared multiplier operand widths
  localparam int unsigned MulAW   = 20;
  localparam int unsigned MulBW   = CntW;
  localparam int unsigned ProdW   = MulAW + MulBW;

  // shared divider: dividend holds mag*remaining or chan*ms*rate
  localparam int unsigned DvdW    = 44;
  localparam int unsigned DivCntW = 6;
  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(DvdW - 1);

  localparam logic [CntW-1:0] MsPerSec = CntW'(1000);

  localparam logic [RateW-1:0] SampleRateRst   = RateW'(44100);
  localparam logic [ChanW-1:0] ChannelCountRst = ChanW'(2);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SAMPLE_RATE   = 2'd0,
    REG_CHANNEL_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_FADE   = 1'b1
  } opcode_e;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL1 = 5'b00010,
    ST_MUL2 = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

endpackage

// File: hw/rtl/linear_fade_out_core.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake                Payload
// in       input      in_valid_i / in_stall_o  opcode_i, sample_in_i, fade_ms_i
// out      output     out_valid_o / out_stall_i sample_out_o, faded_out_o
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A pass-through or zeroed sample is answered in the cycle after its request.
// A scaled sample takes one pass of the 20x27 multiplier (ST_MUL2), 44 restoring divide
// steps (ST_DIV) and a final step (ST_FIN) that registers the result.
// A start-fade request adds a second multiplier pass (ST_MUL1) before ST_MUL2.
// rst_ni clears the state and loads the register defaults. A stalled result holds
// in the output register and stalls the input; a finished sample division waits for it.

module linear_fade_out_core
  import lfo_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,

  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      opcode_i,
  input  logic signed [SampleW-1:0] sample_in_i,
  input  logic        [MsW-1:0]     fade_ms_i,

  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [SampleW-1:0] sample_out_o,
  output logic                      faded_out_o,

  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic        [CfgIdxW-1:0] cfg_index_i,
  input  logic        [RateW-1:0]   cfg_data_i
);

  state_e state_q, state_d;

  logic [RateW-1:0] sample_rate_q, sample_rate_d;
  logic [ChanW-1:0] channel_count_q, channel_count_d;
  logic             fading_q, fading_d;
  logic [CntW-1:0]  total_q, total_d;
  logic [CntW-1:0]  remaining_q, remaining_d;
  logic             out_valid_q, out_valid_d;

  logic                      is_fade_q, is_fade_d;
  logic                      neg_q, neg_d;
  logic [MulAW-1:0]          mul_a_q, mul_a_d;
  logic [MulBW-1:0]          mul_b_q, mul_b_d;
  logic [DvdW-1:0]           dvd_q, dvd_d;
  logic [CntW-1:0]           dsr_q, dsr_d;
  logic [CntW-1:0]           rem_q, rem_d;
  logic [DivCntW-1:0]        cnt_q, cnt_d;
  logic signed [SampleW-1:0] sample_out_q, sample_out_d;
  logic                      faded_q, faded_d;

  logic [ProdW-1:0]  prod;
  logic [CntW:0]     trial;
  logic [CntW:0]     diff;
  logic              out_free;
  logic              in_accept;
  logic [SampleW:0]  mag;
  logic [SampleW:0]  quot;

  assign prod     = mul_a_q * mul_b_q;
  assign trial    = {rem_q, dvd_q[DvdW-1]};
  assign diff     = trial - {1'b0, dsr_q};
  assign out_free = !out_valid_q || !out_stall_i;

  assign in_stall_o  = (state_q != ST_IDLE) || !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign mag  = sample_in_i[SampleW-1] ? ((SampleW+1)'(0) - {1'b1, sample_in_i})
                                       : {1'b0, sample_in_i};
  assign quot = dvd_q[SampleW:0];

  always_comb begin
    state_d         = state_q;
    sample_rate_d   = sample_rate_q;
    channel_count_d = channel_count_q;
    fading_d        = fading_q;
    total_d         = total_q;
    remaining_d     = remaining_q;
    out_valid_d     = out_valid_q && out_stall_i;
    is_fade_d       = is_fade_q;
    neg_d           = neg_q;
    mul_a_d         = mul_a_q;
    mul_b_d         = mul_b_q;
    dvd_d           = dvd_q;
    dsr_d           = dsr_q;
    rem_d           = rem_q;
    cnt_d           = cnt_q;
    sample_out_d    = sample_out_q;
    faded_d         = faded_q;

    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SAMPLE_RATE:   sample_rate_d   = cfg_data_i;
        REG_CHANNEL_COUNT: channel_count_d = cfg_data_i[ChanW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          if (opcode_i == OP_FADE) begin
            is_fade_d = 1'b1;
            mul_a_d   = MulAW'(fade_ms_i);
            mul_b_d   = MulBW'(channel_count_q);
            dsr_d     = MsPerSec;
            state_d   = ST_MUL1;
          end else if (!fading_q) begin
            sample_out_d = sample_in_i;
            faded_d      = 1'b0;
            out_valid_d  = 1'b1;
          end else if (remaining_q == '0 || total_q == '0) begin
            remaining_d  = '0;
            sample_out_d = '0;
            faded_d      = 1'b1;
            out_valid_d  = 1'b1;
          end else begin
            is_fade_d = 1'b0;
            neg_d     = sample_in_i[SampleW-1];
            mul_a_d   = MulAW'(mag);
            mul_b_d   = remaining_q;
            dsr_d     = total_q;
            state_d   = ST_MUL2;
          end
        end
      end
      ST_MUL1: begin
        // channels * ms fits 20 bits; next pass multiplies by the rate
        mul_a_d = prod[MulAW-1:0];
        mul_b_d = MulBW'(sample_rate_q);
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        dvd_d   = prod[DvdW-1:0];
        rem_d   = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!diff[CntW]) begin
          rem_d = diff[CntW-1:0];
        end else begin
          rem_d = trial[CntW-1:0];
        end
        dvd_d = {dvd_q[DvdW-2:0], !diff[CntW]};
        cnt_d = cnt_q + DivCntW'(1);
        if (cnt_q == DivLastStep) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (is_fade_q) begin
          // saturate the fade length to the counter width
          if (|dvd_q[DvdW-1:CntW]) begin
            total_d     = '1;
            remaining_d = '1;
          end else begin
            total_d     = dvd_q[CntW-1:0];
            remaining_d = dvd_q[CntW-1:0];
          end
          fading_d = 1'b1;
          state_d  = ST_IDLE;
        end else if (out_free) begin
          sample_out_d = neg_q ? SampleW'((SampleW+1)'(0) - quot) : quot[SampleW-1:0];
          faded_d      = 1'b0;
          out_valid_d  = 1'b1;
          remaining_d  = remaining_q - CntW'(1);
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      sample_rate_q   <= SampleRateRst;
      channel_count_q <= ChannelCountRst;
      fading_q        <= 1'b0;
      total_q         <= '0;
      remaining_q     <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      sample_rate_q   <= sample_rate_d;
      channel_count_q <= channel_count_d;
      fading_q        <= fading_d;
      total_q         <= total_d;
      remaining_q     <= remaining_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_fade_q    <= is_fade_d;
    neg_q        <= neg_d;
    mul_a_q      <= mul_a_d;
    mul_b_q      <= mul_b_d;
    dvd_q        <= dvd_d;
    dsr_q        <= dsr_d;
    rem_q        <= rem_d;
    cnt_q        <= cnt_d;
    sample_out_q <= sample_out_d;
    faded_q      <= faded_d;
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_out_q;
  assign faded_out_o  = faded_q;

endmodule

// File: verif/linear_fade_out_core_tb.sv
`timescale 1ns / 1ps

module linear_fade_out_core_tb;
  import lfo_pkg::*;

  localparam logic [CntW-1:0] FadeLenMax = '1;
  localparam int unsigned SettleCycles = 80;
  localparam int unsigned HoldOffCycles = 300;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      faded;
  } faded_sample_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                      in_valid_i = 1'b0;
  logic                      in_stall_o;
  logic                      opcode_i = OP_SAMPLE;
  logic signed [SampleW-1:0] sample_in_i = '0;
  logic        [MsW-1:0]     fade_ms_i = '0;

  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic signed [SampleW-1:0] sample_out_o;
  logic                      faded_out_o;

  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic        [CfgIdxW-1:0] cfg_index_i = REG_SAMPLE_RATE;
  logic        [RateW-1:0]   cfg_data_i = '0;

  // predicted block state
  logic [RateW-1:0] rate_cfg = SampleRateRst;
  logic [ChanW-1:0] chan_cfg = ChannelCountRst;
  logic             fade_armed = 1'b0;
  logic [CntW-1:0]  fade_len = '0;
  logic [CntW-1:0]  fade_left = '0;

  faded_sample_t faded_sample_q[$];
  int unsigned   mismatches = 0;
  bit            quiet = 1'b0;
  bit            hold_req = 1'b0;
  bit            hold_active = 1'b0;
  int unsigned   stall_burst = 0;

  linear_fade_out_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .sample_in_i  (sample_in_i),
    .fade_ms_i    (fade_ms_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o),
    .faded_out_o  (faded_out_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(string msg);
    if (mismatches < 50) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
    mismatches++;
  endtask

  // Works out the effect of one accepted request on the gain ramp.
  function automatic void apply_fade(opcode_e op, logic [SampleW-1:0] raw,
                                     logic [MsW-1:0] ms);
    logic [DvdW-1:0]    len;
    logic [SampleW-1:0] mag;
    logic [DvdW-1:0]    quot;
    faded_sample_t      res;
    if (op == OP_FADE) begin
      len = (DvdW'(chan_cfg) * DvdW'(ms) * DvdW'(rate_cfg)) / DvdW'(MsPerSec);
      if (len > DvdW'(FadeLenMax)) begin
        len = DvdW'(FadeLenMax);
      end
      fade_len   = len[CntW-1:0];
      fade_left  = len[CntW-1:0];
      fade_armed = 1'b1;
      return;
    end
    if (!fade_armed) begin
      res = '{sample: raw, faded: 1'b0};
    end else if (fade_left == '0 || fade_len == '0) begin
      fade_left = '0;
      res = '{sample: '0, faded: 1'b1};
    end else begin
      // magnitude of -32768 is 32768, still fits 16 bits unsigned
      mag  = raw[SampleW-1] ? (SampleW'(0) - raw) : raw;
      quot = (DvdW'(mag) * DvdW'(fade_left)) / DvdW'(fade_len);
      res.sample = raw[SampleW-1] ? (SampleW'(0) - quot[SampleW-1:0]) : quot[SampleW-1:0];
      res.faded  = 1'b0;
      fade_left  = fade_left - 1'b1;
    end
    faded_sample_q.push_back(res);
  endfunction

  function automatic int unsigned pick_gap();
    if (quiet || $urandom_range(0, 3) != 0) begin
      return 0;
    end
    return $urandom_range(1, 16);
  endfunction

  // Valid stays high after acceptance; the next call either reuses it or lowers it.
  task automatic send_request(opcode_e op, logic [SampleW-1:0] raw, logic [MsW-1:0] ms);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    sample_in_i <= raw;
    fade_ms_i   <= ms;
    do @(posedge clk_i); while (in_stall_o);
    apply_fade(op, raw, ms);
  endtask

  task automatic send_sample(logic [SampleW-1:0] raw);
    send_request(OP_SAMPLE, raw, MsW'($urandom));
  endtask

  task automatic start_fade(logic [MsW-1:0] ms);
    send_request(OP_FADE, SampleW'($urandom), ms);
  endtask

  // Drop valid, drain the expected results, then let any start-fade finish.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (faded_sample_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [RateW-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_SAMPLE_RATE:   rate_cfg = value;
      REG_CHANNEL_COUNT: chan_cfg = value[ChanW-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_format(logic [RateW-1:0] rate, logic [ChanW-1:0] chans);
    wait_idle();
    write_reg(REG_SAMPLE_RATE, rate);
    write_reg(REG_CHANNEL_COUNT, RateW'(chans));
  endtask

  always @(posedge clk_i) begin
    faded_sample_t exp_res;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (faded_sample_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result sample=%h faded=%b",
                                  sample_out_o, faded_out_o));
      end else begin
        exp_res = faded_sample_q.pop_front();
        if (sample_out_o !== exp_res.sample) begin
          report_mismatch($sformatf("sample_out got %h exp %h",
                                    sample_out_o, exp_res.sample));
        end
        if (faded_out_o !== exp_res.faded) begin
          report_mismatch($sformatf("faded_out got %b exp %b",
                                    faded_out_o, exp_res.faded));
        end
      end
    end
  end

  // receiver stalls: random bursts, plus the long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_active) begin
      out_stall_i <= 1'b1;
    end else if (stall_burst > 0) begin
      out_stall_i <= 1'b1;
      stall_burst = stall_burst - 1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      stall_burst = $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin : hold_off_counter
    forever begin
      wait (hold_req);
      hold_active = 1'b1;
      repeat (HoldOffCycles) @(negedge clk_i);
      hold_active = 1'b0;
      hold_req = 1'b0;
    end
  end

  task automatic test_pass_through();
    send_sample(16'h8000);
    send_sample(16'h7fff);
    send_sample(16'h0000);
    send_sample(16'hffff);
    send_sample(16'h0001);
  endtask

  task automatic test_zero_length();
    start_fade('0);
    send_sample(16'h8000);
    send_sample(16'h7fff);
  endtask

  // eight-sample fade: last scaled sample, then zeroed ones, then a restart
  task automatic test_short_fade();
    set_format(RateW'(8000), ChanW'(1));
    start_fade(MsW'(1));
    send_sample(16'h7fff);
    send_sample(16'h8000);
    repeat (7) send_sample(SampleW'($urandom));
    send_sample(16'h8000);
    start_fade(MsW'(2));
    repeat (3) send_sample(SampleW'($urandom));
  endtask

  // out-of-range registers force the length to saturate; the last, in-range fade does not
  task automatic test_saturation();
    set_format('1, '1);
    start_fade(MsW'(60000));
    send_sample(16'h8000);
    send_sample(16'h7fff);
    // new registers must not touch the running fade
    set_format(RateW'(8000), ChanW'(1));
    send_sample(16'h8000);
    send_sample(16'h7fff);
    set_format(RateW'(192000), ChanW'(8));
    start_fade(MsW'(60000));
    send_sample(16'h8000);
    send_sample(16'h7fff);
  endtask

  task automatic test_back_pressure();
    wait_idle();
    start_fade(MsW'(60000));
    hold_req = 1'b1;
    repeat (40) send_sample(SampleW'($urandom));
  endtask

  task automatic run_random_phase(int unsigned n_items);
    int unsigned pick;
    int unsigned span;
    logic [MsW-1:0] ms;
    for (int unsigned i = 0; i < n_items; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        span = $urandom_range(0, 9);
        if (span < 6) begin
          ms = MsW'($urandom_range(0, 3));
        end else if (span < 8) begin
          ms = MsW'($urandom_range(0, 20));
        end else if (span < 9) begin
          ms = '0;
        end else begin
          ms = MsW'($urandom_range(0, 60000));
        end
        start_fade(ms);
      end else if (pick < 6) begin
        send_sample(16'h8000);
      end else if (pick < 8) begin
        send_sample(16'h7fff);
      end else begin
        send_sample(SampleW'($urandom));
      end
    end
  endtask

  task automatic test_random();
    set_format(RateW'(8000), ChanW'(1));
    run_random_phase(220);
    set_format(RateW'(192000), ChanW'(8));
    run_random_phase(200);
    set_format(RateW'(44100), ChanW'(2));
    run_random_phase(220);
    set_format(RateW'($urandom_range(8000, 192000)), ChanW'($urandom_range(1, 8)));
    run_random_phase(220);
    set_format(RateW'(8000), ChanW'($urandom_range(1, 3)));
    quiet = 1'b1;
    run_random_phase(220);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_pass_through();
    test_zero_length();
    test_short_fade();
    test_saturation();
    test_back_pressure();
    test_random();
    wait_idle();
    if (faded_sample_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", faded_sample_q.size()));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/lfo_pkg.sv
hw/rtl/linear_fade_out_core.sv
verif/linear_fade_out_core_tb.sv
